FILE: rtl/fssmm_pkg.sv
// Package: constants and float32 helper functions for the stream sum/min/max block.
package fssmm_pkg;

  localparam int unsigned MAX_ELEMENTS = 65536;
  localparam int unsigned POS_W = 16;
  localparam int unsigned CNT_W = 17;
  localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
  localparam logic [POS_W-1:0] POS_CAP =
    (MAX_ELEMENTS - 1 > 65535) ? POS_W'(65535) : POS_W'(MAX_ELEMENTS - 1);
  localparam logic [CNT_W-1:0] CNT_CAP =
    (MAX_ELEMENTS > 131071) ? CNT_W'(131071) : CNT_W'(MAX_ELEMENTS);

  localparam logic [0:0] REG_TARGET = 1'b0;

  typedef struct packed {
    logic             is_float;
    logic [31:0]      value_bits;
    logic             is_last;
    logic [POS_W-1:0] index;
  } item_t;

  function automatic logic f_is_nan(input logic [31:0] x);
    f_is_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic f_eq(input logic [31:0] a, input logic [31:0] b);
    if (f_is_nan(a) || f_is_nan(b)) f_eq = 1'b0;
    else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) f_eq = 1'b1;
    else f_eq = (a == b);
  endfunction

  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    if (f_is_nan(a) || f_is_nan(b)) f_lt = 1'b0;
    else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) f_lt = 1'b0;
    else if (a[31] != b[31]) f_lt = a[31];
    else if (a[31]) f_lt = a[30:0] > b[30:0];
    else f_lt = a[30:0] < b[30:0];
  endfunction

endpackage

FILE: rtl/fssmm_fadd.sv
// Combinational float32 adder, round to nearest even, full subnormals.
module fssmm_fadd (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] sum
);

  logic [31:0] big, sml;
  logic [7:0]  ea, eb, e_res;
  logic [8:0]  ex;
  logic [7:0]  d;
  logic [32:0] sa, sb, sh, s;
  logic [31:0] sn;
  logic [5:0]  lz, shamt;
  logic        sub, stk;
  logic [24:0] keep;
  logic [7:0]  rem;

  always_comb begin
    sum = 32'd0;
    stk = 1'b0;
    big = (a[30:0] < b[30:0]) ? b : a;
    sml = (a[30:0] < b[30:0]) ? a : b;
    sub = a[31] ^ b[31];
    ea = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    eb = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    sa = {1'b0, (big[30:23] != 8'd0), big[22:0], 8'd0};
    sb = {1'b0, (sml[30:23] != 8'd0), sml[22:0], 8'd0};
    d = ea - eb;
    if (d >= 8'd40) begin
      sh = {32'd0, (sb != 33'd0)};
    end else begin
      stk = ((sb & ((33'd1 << d[5:0]) - 33'd1)) != 33'd0);
      sh = (sb >> d[5:0]) | {32'd0, stk};
    end
    s = sub ? (sa - sh) : (sa + sh);
    ex = {1'b0, ea};
    if (s[32]) begin
      sn = s[32:1] | {31'd0, s[0]};
      ex = ex + 9'd1;
    end else begin
      sn = s[31:0];
    end
    lz = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (sn[i]) lz = 6'(31 - i);
    end
    shamt = (9'(lz) < ex - 9'd1) ? lz : 6'(ex - 9'd1);
    sn = sn << shamt;
    ex = ex - 9'(shamt);
    keep = {1'b0, sn[31:8]};
    rem = sn[7:0];
    if (rem > 8'h80 || (rem == 8'h80 && keep[0])) keep = keep + 25'd1;
    if (keep[24]) begin
      keep = keep >> 1;
      ex = ex + 9'd1;
    end
    e_res = keep[23] ? ex[7:0] : 8'd0;
    if (fssmm_pkg::f_is_nan(a) || fssmm_pkg::f_is_nan(b)) begin
      sum = fssmm_pkg::QNAN_BITS;
    end else if (a[30:23] == 8'hFF) begin
      sum = (b[30:23] == 8'hFF && sub) ? fssmm_pkg::QNAN_BITS : a;
    end else if (b[30:23] == 8'hFF) begin
      sum = b;
    end else if (s == 33'd0) begin
      sum = sub ? 32'd0 : {big[31], 31'd0};
    end else if (ex >= 9'd255) begin
      sum = {big[31], 31'h7F800000};
    end else begin
      sum = {big[31], e_res, keep[22:0]};
    end
  end

endmodule

FILE: rtl/fssmm_accum.sv
// Running sum, min, max and count registers with result register.
module fssmm_accum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_go,
  input  fssmm_pkg::item_t             item,
  input  logic [31:0]                  target,
  input  logic                         adv,
  output logic                         out_valid,
  output logic                         out_match,
  output logic [fssmm_pkg::POS_W-1:0]  out_index,
  output logic                         out_totals_valid,
  output logic [31:0]                  out_sum_bits,
  output logic [31:0]                  out_min_bits,
  output logic [31:0]                  out_max_bits,
  output logic [fssmm_pkg::CNT_W-1:0]  out_float_count
);

  logic [31:0] sum_r, min_r, max_r, sum_nxt, min_nxt, max_nxt, add_res;
  logic [fssmm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic valid_r;

  fssmm_fadd u_fadd (.a(sum_r), .b(item.value_bits), .sum(add_res));

  always_comb begin
    sum_nxt = sum_r;
    min_nxt = min_r;
    max_nxt = max_r;
    cnt_nxt = cnt_r;
    if (item.is_float) begin
      sum_nxt = add_res;
      if (cnt_r == '0) begin
        min_nxt = item.value_bits;
        max_nxt = item.value_bits;
      end else begin
        if (fssmm_pkg::f_lt(item.value_bits, min_r)) min_nxt = item.value_bits;
        if (fssmm_pkg::f_lt(max_r, item.value_bits)) max_nxt = item.value_bits;
      end
      if (cnt_r < fssmm_pkg::CNT_CAP) cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      min_r <= '0;
      max_r <= '0;
      cnt_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (adv) valid_r <= in_go;
      if (in_go) begin
        if (item.is_last) begin
          sum_r <= '0;
          min_r <= '0;
          max_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          min_r <= min_nxt;
          max_r <= max_nxt;
          cnt_r <= cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      out_match <= item.is_float && fssmm_pkg::f_eq(item.value_bits, target);
      out_index <= item.index;
      out_totals_valid <= item.is_last;
      out_sum_bits <= item.is_last ? sum_nxt : 32'd0;
      out_min_bits <= (item.is_last && cnt_nxt != '0) ? min_nxt : 32'd0;
      out_max_bits <= (item.is_last && cnt_nxt != '0) ? max_nxt : 32'd0;
      out_float_count <= item.is_last ? cnt_nxt : '0;
    end
  end

  assign out_valid = valid_r;

endmodule

FILE: rtl/float_stream_sum_min_max.sv
// Top level: float32 stream sum/min/max reduction with equality search.
//  channel | dir | handshake           | payload
//  in_     | in  | in_valid/in_stall   | is_float, value_bits, is_last
//  out_    | out | out_valid/out_stall | match, index, totals_valid, sum/min/max, count
//  cfg_    | in  | APB psel/penable    | target_bits at 0x0
// One transaction per cycle while the output is not stalled; the result is registered
// in the cycle after accept, and the sum accumulator loop uses a combinational adder.
// Synchronous reset clears totals, position and target.
// A stalled output holds; input is taken while out is empty or being taken.
module float_stream_sum_min_max (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_is_float,
  input  logic [31:0] in_value_bits,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_match,
  output logic [15:0] out_index,
  output logic        out_totals_valid,
  output logic [31:0] out_sum_bits,
  output logic [31:0] out_min_bits,
  output logic [31:0] out_max_bits,
  output logic [16:0] out_float_count,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] target_r;
  logic [fssmm_pkg::POS_W-1:0] pos_r;
  logic adv, in_go;
  fssmm_pkg::item_t item;

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign in_go = in_valid && adv;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == fssmm_pkg::REG_TARGET) ? target_r : 32'd0;

  assign item = '{is_float: in_is_float, value_bits: in_value_bits,
                  is_last: in_is_last, index: pos_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      pos_r <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == fssmm_pkg::REG_TARGET)
        target_r <= cfg_pwdata;
      if (in_go) begin
        if (in_is_last) pos_r <= '0;
        else if (pos_r < fssmm_pkg::POS_CAP) pos_r <= pos_r + 1'b1;
      end
    end
  end

  fssmm_accum u_accum (
    .clk(clk), .rst_n(rst_n), .in_go(in_go), .item(item), .target(target_r),
    .adv(adv), .out_valid(out_valid), .out_match(out_match), .out_index(out_index),
    .out_totals_valid(out_totals_valid), .out_sum_bits(out_sum_bits),
    .out_min_bits(out_min_bits), .out_max_bits(out_max_bits),
    .out_float_count(out_float_count)
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sum_bits) && $stable(out_index))
    else $error("result changed under stall");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction lost");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_is_last |=> pos_r == '0)
    else $error("position not cleared after last");

endmodule

FILE: test/tb_float_stream_sum_min_max.sv
// Testbench for float_stream_sum_min_max: directed and random float32 sets vs. a predictor.
`timescale 1ns / 100ps

module tb_float_stream_sum_min_max;

  localparam int unsigned LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    bit          match;
    logic [15:0] index;
    bit          totals_valid;
    logic [31:0] sum_bits;
    logic [31:0] min_bits;
    logic [31:0] max_bits;
    logic [16:0] float_count;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_is_float = 1'b0;
  logic [31:0] in_value_bits = '0;
  logic        in_is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_match;
  logic [15:0] out_index;
  logic        out_totals_valid;
  logic [31:0] out_sum_bits;
  logic [31:0] out_min_bits;
  logic [31:0] out_max_bits;
  logic [16:0] out_float_count;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [0:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  result_t     results_due[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned sets_closed = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  int unsigned send_idle = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_cnt = 0;

  // predictor state
  logic [31:0] acc_sum, acc_min, acc_max, target;
  logic [16:0] acc_cnt;
  logic [15:0] acc_pos;

  float_stream_sum_min_max uut (.*);

  always #5 clk = ~clk;

  function automatic bit fnan(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic bit feq(input logic [31:0] a, input logic [31:0] b);
    if (fnan(a) || fnan(b)) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b1;
    return a == b;
  endfunction

  function automatic bit flt(input logic [31:0] a, input logic [31:0] b);
    if (fnan(a) || fnan(b)) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    if (a[31] != b[31]) return a[31];
    return a[31] ? (a[30:0] > b[30:0]) : (a[30:0] < b[30:0]);
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a_in, input logic [31:0] b_in);
    logic [31:0] a, b, t, keep;
    logic [63:0] sa, sb, s;
    int unsigned ea, eb, d, expf;
    logic [7:0]  rem;
    bit          sign, sub;
    a = a_in;
    b = b_in;
    if (fnan(a) || fnan(b)) return fssmm_pkg::QNAN_BITS;
    ea = a[30:23];
    eb = b[30:23];
    if (ea == 255) begin
      if (eb == 255 && a[31] != b[31]) return fssmm_pkg::QNAN_BITS;
      return a;
    end
    if (eb == 255) return b;
    if (a[30:0] < b[30:0]) begin
      t = a; a = b; b = t;
      d = ea; ea = eb; eb = d;
    end
    sign = a[31];
    sub = a[31] ^ b[31];
    sa = {40'd0, ea != 0, a[22:0]} << 8;
    sb = {40'd0, eb != 0, b[22:0]} << 8;
    if (ea == 0) ea = 1;
    if (eb == 0) eb = 1;
    d = ea - eb;
    if (d >= 40) sb = (sb != 0) ? 64'd1 : 64'd0;
    else if (d > 0) sb = (sb >> d) | 64'((sb & ((64'd1 << d) - 1)) != 0);
    s = sub ? sa - sb : sa + sb;
    if (s == 0) return sub ? 32'd0 : {sign, 31'd0};
    if (s >= (64'd1 << 32)) begin
      s = (s >> 1) | (s & 64'd1);
      ea++;
    end
    while (s < (64'd1 << 31) && ea > 1) begin
      s = s << 1;
      ea--;
    end
    keep = s[39:8];
    rem = s[7:0];
    if (rem > 8'h80 || (rem == 8'h80 && keep[0])) keep++;
    if (keep >= 32'h100_0000) begin
      keep = keep >> 1;
      ea++;
    end
    if (ea >= 255) return {sign, 8'hFF, 23'd0};
    expf = (keep >= 32'h80_0000) ? ea : 0;
    return {sign, expf[7:0], keep[22:0]};
  endfunction

  task automatic clear_totals();
    acc_sum = '0;
    acc_min = '0;
    acc_max = '0;
    acc_cnt = '0;
    acc_pos = '0;
  endtask

  task automatic accumulate(input bit f, input logic [31:0] v, input bit l);
    result_t r;
    r = '{default: 0};
    r.match = f && feq(v, target);
    r.index = acc_pos;
    if (f) begin
      acc_sum = fadd(acc_sum, v);
      if (acc_cnt == 0) begin
        acc_min = v;
        acc_max = v;
      end else begin
        if (flt(v, acc_min)) acc_min = v;
        if (flt(acc_max, v)) acc_max = v;
      end
      if (acc_cnt < fssmm_pkg::CNT_CAP) acc_cnt++;
    end
    if (acc_pos < fssmm_pkg::POS_CAP) acc_pos++;
    if (l) begin
      r.totals_valid = 1'b1;
      r.sum_bits = acc_sum;
      r.min_bits = acc_cnt != 0 ? acc_min : 32'd0;
      r.max_bits = acc_cnt != 0 ? acc_max : 32'd0;
      r.float_count = acc_cnt;
      sets_closed++;
      clear_totals();
    end
    results_due.insert(results_due.size(), r);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, results_seen);
  endtask

  task automatic send_item(input bit f, input logic [31:0] v, input bit l);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_is_float <= f;
    in_value_bits <= v;
    in_is_last <= l;
    do @(posedge clk); while (in_stall);
    accumulate(f, v, l);
    items_sent++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_target(input logic [31:0] v);
    drain();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= fssmm_pkg::REG_TARGET;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    target = v;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(11))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return {1'($urandom_range(1)), 31'h7F80_0000};
      3: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      4: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
      5: return {1'($urandom_range(1)), 31'h7F7F_FFFF};
      6: return target;
      7, 8, 9: return {1'($urandom_range(1)), 8'($urandom_range(118, 136)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) hold_cnt <= 0;
    else if (hold_req) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("MISMATCH unexpected transaction at cycle %0d", cycles);
      end else begin
        e = results_due.pop_front();
        if (out_match !== e.match) report("match", out_match, e.match);
        if (out_index !== e.index) report("index", out_index, e.index);
        if (out_totals_valid !== e.totals_valid)
          report("totals_valid", out_totals_valid, e.totals_valid);
        if (out_sum_bits !== e.sum_bits) report("sum_bits", out_sum_bits, e.sum_bits);
        if (out_min_bits !== e.min_bits) report("min_bits", out_min_bits, e.min_bits);
        if (out_max_bits !== e.max_bits) report("max_bits", out_max_bits, e.max_bits);
        if (out_float_count !== e.float_count)
          report("float_count", out_float_count, e.float_count);
      end
      results_seen++;
    end
    out_stall <= (hold_cnt != 0) || ($urandom_range(99) < stall_pct);
  end

  // ------------------------------------------------------------------ tests
  task automatic test_directed();
    send_idle = 0;
    stall_pct = 0;
    // zeros, match of -0 against +0 target, -0 + -0
    send_item(1, 32'h8000_0000, 0);
    send_item(1, 32'h8000_0000, 0);
    send_item(0, 32'hFFFF_FFFF, 0);
    send_item(1, 32'h0000_0000, 1);
    // empty set
    send_item(0, 32'h3F80_0000, 1);
    // NaN as first float, then ordinary values
    send_item(1, 32'h7FC0_0001, 0);
    send_item(1, 32'hBF80_0000, 0);
    send_item(1, 32'h3F80_0000, 1);
    // overflow to infinity, then inf + -inf
    send_item(1, 32'h7F7F_FFFF, 0);
    send_item(1, 32'h7F7F_FFFF, 1);
    send_item(1, 32'h7F80_0000, 0);
    send_item(1, 32'hFF80_0000, 1);
    end_burst();
    write_target(32'h3F80_0000);
    // subnormals, cancellation, NaN after seed
    send_item(1, 32'h0000_0001, 0);
    send_item(1, 32'h807F_FFFF, 0);
    send_item(1, 32'h3F80_0000, 0);
    send_item(1, 32'hBF80_0000, 0);
    send_item(1, 32'hFFFF_FFFF, 0);
    send_item(1, 32'h3F80_0000, 1);
    end_burst();
    write_target(32'hFFFF_FFFF);
    send_item(1, 32'hFFFF_FFFF, 0);
    send_item(0, 32'h0000_0000, 1);
    end_burst();
  endtask

  task automatic test_long_set();
    send_idle = 0;
    stall_pct = 0;
    // one long set of floats back to back
    for (int i = 0; i < 60; i++) send_item(1, 32'h3F80_0000, i == 59);
    end_burst();
  endtask

  task automatic test_random(input int unsigned n, input int unsigned idle,
                             input int unsigned stall);
    int unsigned len, sent;
    sent = 0;
    send_idle = idle;
    stall_pct = stall;
    while (sent < n) begin
      len = $urandom_range(1, 12);
      for (int unsigned i = 0; i < len; i++) begin
        send_item($urandom_range(99) < 80, pick_value(),
                  i == len - 1 || $urandom_range(99) < 3);
        sent++;
      end
    end
    end_burst();
  endtask

  task automatic test_pressure();
    send_idle = 0;
    stall_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int i = 0; i < 40; i++) send_item(1'($urandom_range(1)), pick_value(), i % 7 == 6);
    end_burst();
  endtask

  initial begin
    target = '0;
    clear_totals();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_target(32'h0000_0000);
    test_long_set();
    write_target($urandom);
    test_random(130, 0, 0);
    write_target(32'h3F80_0000);
    test_random(130, 78, 0);
    write_target(32'h8000_0000);
    test_random(130, 0, 78);
    write_target(32'h7F80_0000);
    test_random(130, 31, 31);
    write_target(32'hFFFF_FFFF);
    test_pressure();
    stall_pct = 0;
    drain();
    $display("Sent %0d transactions in %0d sets, checked %0d results.",
             items_sent, sets_closed, results_seen);
    $display("Covered zeros, NaN, infinities, subnormals, long sets, idling and backpressure.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fssmm_pkg.sv
rtl/fssmm_fadd.sv
rtl/fssmm_accum.sv
rtl/float_stream_sum_min_max.sv
test/tb_float_stream_sum_min_max.sv
